/* rtl/tlbpt_pkg.sv */
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared sizes, controller states and controller/datapath interface structs
// for the TLB and page-table translation core.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

   // geometry of the translation structures
   localparam int TLB_ENTRIES = 4;
   localparam int PAGE_COUNT  = 16;
   localparam int FRAME_COUNT = 8;
   localparam int PAGE_BYTES  = 256;

   localparam int TLB_W    = $clog2(TLB_ENTRIES);
   localparam int PAGE_W   = $clog2(PAGE_COUNT);
   localparam int FRAME_W  = $clog2(FRAME_COUNT);
   localparam int OFFSET_W = $clog2(PAGE_BYTES);
   localparam int FREE_W   = $clog2(FRAME_COUNT + 1);
   localparam int SCAN_W   = $clog2(PAGE_COUNT + 1);

   localparam int ADDR_W  = 12;
   localparam int PHYS_W  = 11;
   localparam int STAMP_W = 32;
   localparam int COUNT_W = 16;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_TABLE,
      ST_SCAN,
      ST_EVICT,
      ST_REFILL,
      ST_DONE
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic hit_update;
      logic resident;
      logic take_free;
      logic scan_init;
      logic scan_step;
      logic evict;
      logic refill;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic tlb_hit;
      logic page_resident;
      logic frame_free;
      logic scan_last;
   } status_type;

endpackage

/* rtl/tlbpt_ctrl.sv */
// ----------------------------------------------------------------------------
// tlbpt_ctrl
// Sequencer for one translation: lookup, page-table access, LRU scan,
// eviction, TLB refill and result strobe.
// ----------------------------------------------------------------------------
module tlbpt_ctrl
   import tlbpt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       done
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (status.tlb_hit) begin
               cmd.hit_update = 1'b1;
               state_in       = ST_DONE;
            end else begin
               state_in = ST_TABLE;
            end
         end
         ST_TABLE: begin
            if (status.page_resident) begin
               cmd.resident = 1'b1;
               state_in     = ST_REFILL;
            end else if (status.frame_free) begin
               cmd.take_free = 1'b1;
               state_in      = ST_REFILL;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            cmd.evict = 1'b1;
            state_in  = ST_REFILL;
         end
         ST_REFILL: begin
            cmd.refill = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   assign done = (state_ff == ST_DONE);

endmodule

/* rtl/tlbpt_datapath.sv */
// ----------------------------------------------------------------------------
// tlbpt_datapath
// TLB registers, page-table valid bits, frame and stamp memories, LRU scan
// registers, counters and result registers.
// ----------------------------------------------------------------------------
module tlbpt_datapath
   import tlbpt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [ADDR_W-1:0]  addr,
   output status_type         status,
   output logic [PHYS_W-1:0]  phys_addr,
   output logic               tlb_hit,
   output logic               page_fault,
   output logic               evicted,
   output logic [PAGE_W-1:0]  evicted_page,
   output logic [FRAME_W-1:0] frame_used,
   output logic [TLB_W-1:0]   tlb_slot,
   output logic [COUNT_W-1:0] hit_total,
   output logic [COUNT_W-1:0] fault_total
);

   // request and global state
   logic [ADDR_W-1:0]  addr_ff;
   logic [STAMP_W-1:0] time_ff;
   logic [STAMP_W-1:0] time_in;
   logic [COUNT_W-1:0] hit_count_ff;
   logic [COUNT_W-1:0] fault_count_ff;
   logic [FREE_W-1:0]  next_free_ff;

   // tlb entries
   logic [TLB_ENTRIES-1:0] tlb_valid_ff;
   logic [PAGE_W-1:0]      tlb_page_ff  [TLB_ENTRIES];
   logic [FRAME_W-1:0]     tlb_frame_ff [TLB_ENTRIES];
   logic [STAMP_W-1:0]     tlb_stamp_ff [TLB_ENTRIES];

   // page table
   logic [PAGE_COUNT-1:0] table_valid_ff;
   logic [FRAME_W-1:0]    frame_mem [PAGE_COUNT];
   logic [STAMP_W-1:0]    stamp_mem [PAGE_COUNT];
   logic [FRAME_W-1:0]    rd_frame_ff;
   logic [STAMP_W-1:0]    rd_stamp_ff;
   logic [PAGE_W-1:0]     rd_addr;
   logic                  frame_we;
   logic                  stamp_we;
   logic [FRAME_W-1:0]    wr_frame;

   // lru scan
   logic [SCAN_W-1:0]  scan_cnt_ff;
   logic               scan_active_ff;
   logic [STAMP_W-1:0] best_stamp_ff;
   logic [PAGE_W-1:0]  best_page_ff;
   logic [FRAME_W-1:0] best_frame_ff;
   logic               found_ff;
   logic [PAGE_W-1:0]  prev_idx;
   logic               better;

   // result registers
   logic [FRAME_W-1:0] frame_ff;
   logic [TLB_W-1:0]   slot_ff;
   logic               hit_ff;
   logic               fault_ff;
   logic               ev_ff;
   logic [PAGE_W-1:0]  ev_page_ff;

   // lookup and victim selection
   logic [PAGE_W-1:0]   page;
   logic                hit;
   logic [TLB_W-1:0]    hit_slot;
   logic                any_invalid;
   logic [TLB_W-1:0]    free_slot;
   logic [TLB_W-1:0]    lru_slot;
   logic [STAMP_W-1:0]  lru_stamp;
   logic [TLB_W-1:0]    victim_slot;

   assign page    = addr_ff[OFFSET_W +: PAGE_W];
   assign time_in = time_ff + STAMP_W'(1);

   // fully associative compare, lowest index wins
   always_comb begin
      hit      = 1'b0;
      hit_slot = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (tlb_valid_ff[i] && (tlb_page_ff[i] == page)) begin
            hit      = 1'b1;
            hit_slot = TLB_W'(i);
         end
      end
   end

   // refill victim: lowest invalid entry, else oldest stamp
   always_comb begin
      any_invalid = 1'b0;
      free_slot   = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (!tlb_valid_ff[i]) begin
            any_invalid = 1'b1;
            free_slot   = TLB_W'(i);
         end
      end
      lru_slot  = '0;
      lru_stamp = tlb_stamp_ff[0];
      for (int i = 1; i < TLB_ENTRIES; i++) begin
         if (tlb_stamp_ff[i] < lru_stamp) begin
            lru_slot  = TLB_W'(i);
            lru_stamp = tlb_stamp_ff[i];
         end
      end
      victim_slot = any_invalid ? free_slot : lru_slot;
   end

   // scan compare on the entry read in the previous cycle
   assign prev_idx = scan_cnt_ff[PAGE_W-1:0] - PAGE_W'(1);
   assign better   = table_valid_ff[prev_idx] &&
                     (!found_ff || (rd_stamp_ff < best_stamp_ff));

   // page table memories, one write and one read address
   assign rd_addr  = scan_active_ff ? scan_cnt_ff[PAGE_W-1:0] : page;
   assign frame_we = cmd.take_free || cmd.evict;
   assign stamp_we = cmd.hit_update || cmd.resident || cmd.take_free || cmd.evict;
   assign wr_frame = cmd.take_free ? next_free_ff[FRAME_W-1:0] :
                     (found_ff ? best_frame_ff : '0);

   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[page] <= wr_frame;
      end
      if (stamp_we) begin
         stamp_mem[page] <= time_ff;
      end
      rd_frame_ff <= frame_mem[rd_addr];
      rd_stamp_ff <= stamp_mem[rd_addr];
   end

   // control state: counters, valid bits, scan progress
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff        <= '0;
         hit_count_ff   <= '0;
         fault_count_ff <= '0;
         next_free_ff   <= '0;
         tlb_valid_ff   <= '0;
         table_valid_ff <= '0;
         scan_cnt_ff    <= '0;
         scan_active_ff <= 1'b0;
         found_ff       <= 1'b0;
      end else begin
         if (cmd.load) begin
            time_ff <= time_in;
         end
         if (cmd.hit_update && (hit_count_ff != '1)) begin
            hit_count_ff <= hit_count_ff + COUNT_W'(1);
         end
         if ((cmd.take_free || cmd.scan_init) && (fault_count_ff != '1)) begin
            fault_count_ff <= fault_count_ff + COUNT_W'(1);
         end
         if (cmd.take_free) begin
            next_free_ff             <= next_free_ff + FREE_W'(1);
            table_valid_ff[page]     <= 1'b1;
         end
         if (cmd.scan_init) begin
            scan_cnt_ff    <= '0;
            scan_active_ff <= 1'b1;
            found_ff       <= 1'b0;
         end
         if (cmd.scan_step) begin
            scan_cnt_ff <= scan_cnt_ff + SCAN_W'(1);
            if (scan_cnt_ff == SCAN_W'(PAGE_COUNT)) begin
               scan_active_ff <= 1'b0;
            end
            if ((scan_cnt_ff != '0) && better) begin
               found_ff <= 1'b1;
            end
         end
         // eviction drops the victim from the table and the tlb
         if (cmd.evict) begin
            table_valid_ff[page] <= 1'b1;
            if (found_ff) begin
               table_valid_ff[best_page_ff] <= 1'b0;
               for (int i = 0; i < TLB_ENTRIES; i++) begin
                  if (tlb_page_ff[i] == best_page_ff) begin
                     tlb_valid_ff[i] <= 1'b0;
                  end
               end
            end
         end
         if (cmd.refill) begin
            tlb_valid_ff[victim_slot] <= 1'b1;
         end
      end
   end

   // payload: tlb contents, scan best, result fields
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff    <= addr;
         hit_ff     <= 1'b0;
         fault_ff   <= 1'b0;
         ev_ff      <= 1'b0;
         ev_page_ff <= '0;
      end
      if (cmd.hit_update) begin
         hit_ff                 <= 1'b1;
         slot_ff                <= hit_slot;
         frame_ff               <= tlb_frame_ff[hit_slot];
         tlb_stamp_ff[hit_slot] <= time_ff;
      end
      if (cmd.resident) begin
         frame_ff <= rd_frame_ff;
      end
      if (cmd.take_free) begin
         fault_ff <= 1'b1;
         frame_ff <= next_free_ff[FRAME_W-1:0];
      end
      if (cmd.scan_init) begin
         fault_ff <= 1'b1;
      end
      if (cmd.scan_step && (scan_cnt_ff != '0) && better) begin
         best_stamp_ff <= rd_stamp_ff;
         best_page_ff  <= prev_idx;
         best_frame_ff <= rd_frame_ff;
      end
      if (cmd.evict) begin
         frame_ff   <= wr_frame;
         ev_ff      <= found_ff;
         ev_page_ff <= found_ff ? best_page_ff : '0;
      end
      if (cmd.refill) begin
         slot_ff                   <= victim_slot;
         tlb_page_ff[victim_slot]  <= page;
         tlb_frame_ff[victim_slot] <= frame_ff;
         tlb_stamp_ff[victim_slot] <= time_ff;
      end
   end

   // status to the controller
   assign status.tlb_hit       = hit;
   assign status.page_resident = table_valid_ff[page];
   assign status.frame_free    = (next_free_ff < FREE_W'(FRAME_COUNT));
   assign status.scan_last     = (scan_cnt_ff == SCAN_W'(PAGE_COUNT));

   // result fields
   assign phys_addr    = PHYS_W'({frame_ff, addr_ff[OFFSET_W-1:0]});
   assign tlb_hit      = hit_ff;
   assign page_fault   = fault_ff;
   assign evicted      = ev_ff;
   assign evicted_page = ev_page_ff;
   assign frame_used   = frame_ff;
   assign tlb_slot     = slot_ff;
   assign hit_total    = hit_count_ff;
   assign fault_total  = fault_count_ff;

endmodule

/* rtl/tlb_page_table_lru_translate_core.sv */
// ----------------------------------------------------------------------------
// tlb_page_table_lru_translate_core
// Logical to physical translation through a 4-entry fully associative TLB
// and a 16-page demand-paged table over 8 frames, both with LRU replacement.
//
//   channel   ports                       handshake
//   request   req_logical_address         start, accepted when busy is low
//   response  rsp_* (nine fields)         rsp_valid, one-cycle strobe
//
// A TLB hit goes from ST_LOOK to ST_DONE; a miss without eviction also passes
// through ST_TABLE and ST_REFILL. A fault with all frames in use adds ST_SCAN
// and ST_EVICT: the LRU victim search reads the page-table stamp memory one
// entry per cycle over 16 pages.
// Reset is synchronous and clears all valid bits, counters and the time base.
// The response cannot be stalled; busy stays high until the strobe cycle ends.
// ----------------------------------------------------------------------------
module tlb_page_table_lru_translate_core
   import tlbpt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [ADDR_W-1:0]  req_logical_address,
   output logic               rsp_valid,
   output logic [PHYS_W-1:0]  rsp_physical_address,
   output logic               rsp_tlb_hit,
   output logic               rsp_page_fault,
   output logic               rsp_evicted,
   output logic [PAGE_W-1:0]  rsp_evicted_page,
   output logic [FRAME_W-1:0] rsp_frame_used,
   output logic [TLB_W-1:0]   rsp_tlb_slot,
   output logic [COUNT_W-1:0] rsp_hit_total,
   output logic [COUNT_W-1:0] rsp_fault_total
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   tlbpt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .done   (rsp_valid)
   );

   // translation datapath
   tlbpt_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .addr         (req_logical_address),
      .status       (status),
      .phys_addr    (rsp_physical_address),
      .tlb_hit      (rsp_tlb_hit),
      .page_fault   (rsp_page_fault),
      .evicted      (rsp_evicted),
      .evicted_page (rsp_evicted_page),
      .frame_used   (rsp_frame_used),
      .tlb_slot     (rsp_tlb_slot),
      .hit_total    (rsp_hit_total),
      .fault_total  (rsp_fault_total)
   );

   // a result transfer only ends a busy period
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // an accepted request makes the core busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted request did not start a translation");

   // a tlb hit never faults
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tlb_hit) |-> !rsp_page_fault)
      else $error("tlb hit reported together with page fault");

   // eviction only happens on a fault
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted) |-> rsp_page_fault)
      else $error("eviction without page fault");

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the TLB and page-table translation core. A queue
// of logical addresses (a directed opening, then locality-shaped random
// traffic) feeds a falling-edge driver. The driver spaces out the start
// pulses with random idle bursts. At each rising edge a monitor runs every
// accepted address through a local TLB/page-table model and queues the
// expected translation. It then checks each response strobe, field by
// field, against the oldest queued translation.
// ----------------------------------------------------------------------------
module tb;
   import tlbpt_pkg::*;

   localparam int RANDOM_ITEMS = 1430;
   localparam int CALM_TAIL    = 150;
   localparam int DRAIN_EVERY  = 250;
   localparam int IDLE_LIMIT   = 1000;
   localparam int SETTLE       = 40;

   // one expected translation
   typedef struct packed {
      logic [PHYS_W-1:0]  phys;
      logic               tlb_hit;
      logic               fault;
      logic               evicted;
      logic [PAGE_W-1:0]  ev_page;
      logic [FRAME_W-1:0] frame;
      logic [TLB_W-1:0]   slot;
      logic [COUNT_W-1:0] hit_total;
      logic [COUNT_W-1:0] fault_total;
   } xlate_type;

   // one pending access for the driver
   typedef struct {
      logic [ADDR_W-1:0] addr;
      bit                drain;
      bit                calm;
   } access_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [ADDR_W-1:0]  req_logical_address;
   logic               rsp_valid;
   logic [PHYS_W-1:0]  rsp_physical_address;
   logic               rsp_tlb_hit;
   logic               rsp_page_fault;
   logic               rsp_evicted;
   logic [PAGE_W-1:0]  rsp_evicted_page;
   logic [FRAME_W-1:0] rsp_frame_used;
   logic [TLB_W-1:0]   rsp_tlb_slot;
   logic [COUNT_W-1:0] rsp_hit_total;
   logic [COUNT_W-1:0] rsp_fault_total;

   tlb_page_table_lru_translate_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_logical_address  (req_logical_address),
      .rsp_valid            (rsp_valid),
      .rsp_physical_address (rsp_physical_address),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_evicted          (rsp_evicted),
      .rsp_evicted_page     (rsp_evicted_page),
      .rsp_frame_used       (rsp_frame_used),
      .rsp_tlb_slot         (rsp_tlb_slot),
      .rsp_hit_total        (rsp_hit_total),
      .rsp_fault_total      (rsp_fault_total)
   );

   // translation model state
   bit                 tlb_ok   [TLB_ENTRIES];
   logic [PAGE_W-1:0]  tlb_pg   [TLB_ENTRIES];
   logic [FRAME_W-1:0] tlb_frm  [TLB_ENTRIES];
   logic [STAMP_W-1:0] tlb_time [TLB_ENTRIES];
   bit                 pt_ok    [PAGE_COUNT];
   logic [FRAME_W-1:0] pt_frm   [PAGE_COUNT];
   logic [STAMP_W-1:0] pt_time  [PAGE_COUNT];
   int unsigned        free_frame;
   logic [STAMP_W-1:0] now_stamp;
   logic [COUNT_W-1:0] hit_cnt;
   logic [COUNT_W-1:0] fault_cnt;

   access_type access_q[$];
   xlate_type  xlate_q[$];

   int sent_count;
   int taken_count;
   int idle_cycles;
   int fail_count;
   int gap_left;
   bit calm_now;
   int seen_hits;
   int seen_faults;
   int seen_evicts;
   int checked;
   int directed_items;

   // lookup, fault handling and refill for one access
   function automatic xlate_type predict_access(input logic [ADDR_W-1:0] addr);
      xlate_type          r;
      logic [PAGE_W-1:0]  pg;
      logic [FRAME_W-1:0] frm;
      int                 i;
      int                 slot;
      int                 victim;
      bit                 hit;
      bit                 found;
      pg = addr[OFFSET_W +: PAGE_W];
      r = '0;
      hit = 1'b0;
      slot = 0;
      frm = '0;
      now_stamp = now_stamp + STAMP_W'(1);
      for (i = 0; i < TLB_ENTRIES; i++)
         if (!hit && tlb_ok[i] && tlb_pg[i] == pg) begin
            hit = 1'b1;
            slot = i;
         end
      if (hit) begin
         if (hit_cnt != '1) hit_cnt = hit_cnt + COUNT_W'(1);
         tlb_time[slot] = now_stamp;
         pt_time[pg] = now_stamp;
         frm = tlb_frm[slot];
      end else begin
         if (pt_ok[pg]) begin
            frm = pt_frm[pg];
         end else begin
            r.fault = 1'b1;
            if (fault_cnt != '1) fault_cnt = fault_cnt + COUNT_W'(1);
            if (free_frame < FRAME_COUNT) begin
               frm = FRAME_W'(free_frame);
               free_frame++;
            end else begin
               // oldest resident page loses its frame, ties to the lowest page
               found = 1'b0;
               victim = 0;
               for (i = 0; i < PAGE_COUNT; i++)
                  if (pt_ok[i] && (!found || pt_time[i] < pt_time[victim])) begin
                     victim = i;
                     found = 1'b1;
                  end
               if (found) begin
                  r.evicted = 1'b1;
                  r.ev_page = PAGE_W'(victim);
                  frm = pt_frm[victim];
                  pt_ok[victim] = 1'b0;
                  for (i = 0; i < TLB_ENTRIES; i++)
                     if (tlb_ok[i] && tlb_pg[i] == PAGE_W'(victim)) tlb_ok[i] = 1'b0;
               end
            end
            pt_ok[pg] = 1'b1;
            pt_frm[pg] = frm;
         end
         pt_time[pg] = now_stamp;
         // refill: first free entry, else the oldest, ties to the lowest index
         slot = -1;
         for (i = 0; i < TLB_ENTRIES; i++)
            if (slot < 0 && !tlb_ok[i]) slot = i;
         if (slot < 0) begin
            slot = 0;
            for (i = 1; i < TLB_ENTRIES; i++)
               if (tlb_time[i] < tlb_time[slot]) slot = i;
         end
         tlb_ok[slot] = 1'b1;
         tlb_pg[slot] = pg;
         tlb_frm[slot] = frm;
         tlb_time[slot] = now_stamp;
      end
      r.tlb_hit = hit;
      r.frame = frm;
      r.slot = TLB_W'(slot);
      r.phys = {frm, addr[OFFSET_W-1:0]};
      r.hit_total = hit_cnt;
      r.fault_total = fault_cnt;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // driver: one transfer at a time, random idle bursts between items
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken_count == sent_count) begin
         if (start && !calm_now && $urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 9);
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (access_q.size() > 0 && !(access_q[0].drain && xlate_q.size() > 0)) begin
            calm_now = access_q[0].calm;
            req_logical_address <= access_q[0].addr;
            void'(access_q.pop_front());
            start <= 1'b1;
            sent_count++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: predict on each accepted request, check each response strobe
   always @(posedge clock) begin : observe
      xlate_type got;
      xlate_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid) begin
            got.phys = rsp_physical_address;
            got.tlb_hit = rsp_tlb_hit;
            got.fault = rsp_page_fault;
            got.evicted = rsp_evicted;
            got.ev_page = rsp_evicted_page;
            got.frame = rsp_frame_used;
            got.slot = rsp_tlb_slot;
            got.hit_total = rsp_hit_total;
            got.fault_total = rsp_fault_total;
            if (xlate_q.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual phys %0d",
                        $time, got.phys);
               fail_count++;
            end else begin
               want = xlate_q.pop_front();
               check_field("physical_address", 32'(want.phys), 32'(got.phys));
               check_field("tlb_hit", 32'(want.tlb_hit), 32'(got.tlb_hit));
               check_field("page_fault", 32'(want.fault), 32'(got.fault));
               check_field("evicted", 32'(want.evicted), 32'(got.evicted));
               check_field("evicted_page", 32'(want.ev_page), 32'(got.ev_page));
               check_field("frame_used", 32'(want.frame), 32'(got.frame));
               check_field("tlb_slot", 32'(want.slot), 32'(got.slot));
               check_field("hit_total", 32'(want.hit_total), 32'(got.hit_total));
               check_field("fault_total", 32'(want.fault_total), 32'(got.fault_total));
               checked++;
               seen_hits += int'(want.tlb_hit);
               seen_faults += int'(want.fault);
               seen_evicts += int'(want.evicted);
            end
         end
         if (start && !busy) begin
            xlate_q.push_back(predict_access(req_logical_address));
            taken_count++;
         end
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      while (idle_cycles < IDLE_LIMIT) @(negedge clock);
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("tb: FAIL");
      $finish;
   end

   // stimulus and end of run
   initial begin : main
      logic [ADDR_W-1:0] directed [];
      access_type        a;
      logic [PAGE_W-1:0] pg;
      logic [7:0]        ofs;
      logic [PAGE_W-1:0] ws_base;
      int                n;
      int                sel;
      bit                quiet;

      directed = '{
         12'h000, 12'h0FF, 12'hFFF, 12'hF00, 12'h555, 12'hAAA, 12'h1A5, 12'h237,
         12'h3C0, 12'h401, 12'h680, 12'h0AA, 12'h733, 12'hF10, 12'h777, 12'h255,
         12'h8FE, 12'h901, 12'hA5A, 12'hBC3, 12'hC00, 12'hD7F, 12'hE80, 12'hE01,
         12'h000};
      reset = 1'b1;
      start = 1'b0;
      req_logical_address = '0;
      gap_left = 0;
      calm_now = 1'b0;
      sent_count = 0;
      taken_count = 0;
      idle_cycles = 0;
      fail_count = 0;
      checked = 0;
      seen_hits = 0;
      seen_faults = 0;
      seen_evicts = 0;
      for (n = 0; n < TLB_ENTRIES; n++) begin
         tlb_ok[n] = 1'b0;
         tlb_pg[n] = '0;
         tlb_frm[n] = '0;
         tlb_time[n] = '0;
      end
      for (n = 0; n < PAGE_COUNT; n++) begin
         pt_ok[n] = 1'b0;
         pt_frm[n] = '0;
         pt_time[n] = '0;
      end
      free_frame = 0;
      now_stamp = '0;
      hit_cnt = '0;
      fault_cnt = '0;

      // directed: field extremes, hits, resident misses, fills and evictions
      directed_items = directed.size();
      foreach (directed[i]) begin
         a.addr = directed[i];
         a.drain = 1'b0;
         a.calm = 1'b0;
         access_q.push_back(a);
      end

      // random: a drifting working set for hits, a wider window for evictions
      ws_base = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
      quiet = 1'b0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 39) == 0) ws_base = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
         if ($urandom_range(0, 59) == 0) quiet = !quiet;
         sel = $urandom_range(0, 99);
         if (sel < 45) pg = ws_base + PAGE_W'($urandom_range(0, 3));
         else if (sel < 85) pg = ws_base + PAGE_W'($urandom_range(0, 9));
         else pg = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
         ofs = 8'($urandom_range(0, 255));
         a.addr = {pg, ofs};
         a.drain = (n % DRAIN_EVERY == 0);
         a.calm = quiet || (n >= RANDOM_ITEMS - CALM_TAIL);
         access_q.push_back(a);
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (access_q.size() != 0 || taken_count != sent_count || xlate_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (xlate_q.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, xlate_q.size());
         fail_count++;
      end

      $display("tb: %0d translations checked (%0d directed), %0d tlb hits", checked,
               directed_items, seen_hits);
      $display("tb: %0d page faults, %0d evictions, %0d field mismatches", seen_faults,
               seen_evicts, fail_count);
      if (fail_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/tlbpt_pkg.sv
rtl/tlbpt_ctrl.sv
rtl/tlbpt_datapath.sv
rtl/tlb_page_table_lru_translate_core.sv
test/tb.sv
